// ===== src/gcs_pkg.sv =====
// shared types, character codes and constants for the gap comment segmenter
package gcs_pkg;

  // default gap size that bounds the saturating byte position
  localparam int unsigned GCS_MAX_GAP_BYTES = 32'd65536;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_SLASH = 5'b00010,
    MODE_LINE  = 5'b00100,
    MODE_BLOCK = 5'b01000,
    MODE_STAR  = 5'b10000
  } scan_mode_e;

  typedef enum logic [1:0] {
    KIND_COMMENT   = 2'd0,
    KIND_DIRECTIVE = 2'd1,
    KIND_UNKNOWN   = 2'd2
  } seg_kind_e;

  // scanner state carried from one word to the next
  typedef struct packed {
    scan_mode_e  mode;
    logic [15:0] pos;
    logic [15:0] start;
    seg_kind_e   kind;
    logic        sat;
    logic        full;
  } scan_state_t;

  // one reported segment
  typedef struct packed {
    seg_kind_e   kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        ovf;
  } seg_result_t;

endpackage

// ===== src/gap_comment_segmenter.sv =====
// top level of the gap comment segmenter: stream ports, state and result register
//
// scans the bytes of a text gap, one byte per word on the slave stream, with
// tlast on the final byte of the gap. leading space, tab, cr and lf are skipped;
// a segment opened by slash-star runs to the matching star-slash (inclusive),
// any other segment runs up to the next lf (excluded). lines opened by hash or
// by two slashes are comments, by dollar directives, the rest unknown. one word
// leaves on the master stream for each segment, on the byte that ends it: the
// kind in tuser, start offset, length and an overflow flag in tdata. a segment
// still open at the end of the gap runs to its last byte. with comments_only
// set, directive and unknown segments are dropped. the block takes one byte
// every clock: the scanner state is updated by a single short step of logic on
// each accepted byte and the segment is held in one output register, which
// stalls the input only while it is full and not being taken. positions count
// up to min(MAX_GAP_BYTES, 65536) - 1 and then hold, flagging overflow for the
// rest of the gap. no clearing pass after reset.
module gap_comment_segmenter
  import gcs_pkg::*;
#(
  parameter int unsigned MAX_GAP_BYTES = GCS_MAX_GAP_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // comments_only
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic        s_axis_tlast,    // last_of_gap
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,    // [15:0] start, [31:16] length, [32] overflow
  output logic [1:0]  m_axis_tuser     // [1:0] segment_kind
);

  // highest byte offset the position counter reaches
  localparam int unsigned CapBytes = (MAX_GAP_BYTES > 32'd65536) ? 32'd65536 : MAX_GAP_BYTES;
  localparam logic [15:0] PosCap   = 16'(CapBytes - 32'd1);

  logic        comments_only_q;
  scan_state_t state_q, state_d;
  logic        emit;
  seg_result_t res_d, res_q;
  logic        out_valid_q;
  logic        accept;

  // output register frees when empty or being taken this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  gcs_step #(
    .PosCap (PosCap)
  ) u_step (
    .cur_i           (state_q),
    .byte_i          (s_axis_tdata),
    .last_i          (s_axis_tlast),
    .comments_only_i (comments_only_q),
    .nxt_o           (state_d),
    .emit_o          (emit),
    .res_o           (res_d)
  );

  // configuration and scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comments_only_q <= 1'b0;
      state_q.mode    <= MODE_IDLE;
      state_q.pos     <= '0;
      state_q.start   <= '0;
      state_q.kind    <= KIND_COMMENT;
      state_q.sat     <= 1'b0;
      state_q.full    <= 1'b0;
    end else begin
      if (cfg_we_i) comments_only_q <= cfg_wdata_i;
      if (accept) state_q <= state_d;
    end
  end

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && emit) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tdata  = {7'd0, res_q.ovf, res_q.len, res_q.start};

`ifndef SYNTHESIS
  // an empty result register never stalls the byte stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // end of gap returns the scanner to idle at offset zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (state_q.mode == MODE_IDLE && state_q.pos == '0 &&
                                  !state_q.sat && !state_q.full))
    else $error("scanner not cleared after last byte of gap");

  // position only flagged full once it sits on the cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.full |-> (state_q.pos == PosCap))
    else $error("full flag set below position cap");

  // comments-only mode lets nothing but comments through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && comments_only_q) |-> (m_axis_tuser == KIND_COMMENT))
    else $error("non-comment segment reported in comments-only mode");

  // a new result is loaded only from an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(accept))
    else $error("result appeared without an accepted byte");
`endif

endmodule

// ===== src/gcs_step.sv =====
// next-state and segment result logic for one gap byte
module gcs_step
  import gcs_pkg::*;
#(
  parameter logic [15:0] PosCap = 16'hFFFF
) (
  input  scan_state_t cur_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  input  logic        comments_only_i,
  output scan_state_t nxt_o,
  output logic        emit_o,
  output seg_result_t res_o
);

  logic        sat_eff;
  logic        done;
  logic        incl;
  logic        fin;
  scan_mode_e  mode_d;
  seg_kind_e   kind_d;
  seg_kind_e   fin_kind;
  logic [15:0] start_d;
  logic [16:0] len_full;

  always_comb begin
    sat_eff  = cur_i.sat | cur_i.full;
    mode_d   = cur_i.mode;
    kind_d   = cur_i.kind;
    start_d  = cur_i.start;
    done     = 1'b0;
    incl     = 1'b0;
    fin_kind = cur_i.kind;

    case (cur_i.mode)
      MODE_SLASH: begin
        if (byte_i == CH_STAR) begin
          mode_d = MODE_BLOCK;
          kind_d = KIND_COMMENT;
        end else if (byte_i == CH_SLASH) begin
          mode_d = MODE_LINE;
          kind_d = KIND_COMMENT;
        end else if (byte_i == CH_LF) begin
          done     = 1'b1;
          fin_kind = KIND_UNKNOWN;
          mode_d   = MODE_IDLE;
        end else begin
          mode_d = MODE_LINE;
          kind_d = KIND_UNKNOWN;
        end
      end
      MODE_LINE: begin
        if (byte_i == CH_LF) begin
          done     = 1'b1;
          fin_kind = cur_i.kind;
          mode_d   = MODE_IDLE;
        end
      end
      MODE_BLOCK: begin
        if (byte_i == CH_STAR) mode_d = MODE_STAR;
      end
      MODE_STAR: begin
        if (byte_i == CH_SLASH) begin
          done     = 1'b1;
          incl     = 1'b1;
          fin_kind = KIND_COMMENT;
          mode_d   = MODE_IDLE;
        end else if (byte_i != CH_STAR) begin
          mode_d = MODE_BLOCK;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        if (!(byte_i inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})) begin
          start_d = cur_i.pos;
          if (byte_i == CH_SLASH) begin
            mode_d = MODE_SLASH;
            kind_d = KIND_UNKNOWN;
          end else begin
            mode_d = MODE_LINE;
            case (byte_i)
              CH_HASH:   kind_d = KIND_COMMENT;
              CH_DOLLAR: kind_d = KIND_DIRECTIVE;
              default:   kind_d = KIND_UNKNOWN;
            endcase
          end
        end
      end
    endcase

    // end of gap closes whatever segment is still open
    fin = done;
    if (last_i && !done && mode_d != MODE_IDLE) begin
      fin      = 1'b1;
      incl     = 1'b1;
      fin_kind = kind_d;
    end

    len_full = {1'b0, cur_i.pos} - {1'b0, start_d} + {16'd0, incl};

    res_o.kind  = fin_kind;
    res_o.start = start_d;
    res_o.len   = len_full[16] ? 16'hFFFF : len_full[15:0];
    res_o.ovf   = sat_eff | len_full[16];
    emit_o      = fin & (!comments_only_i | (fin_kind == KIND_COMMENT));

    if (last_i) begin
      nxt_o.mode  = MODE_IDLE;
      nxt_o.pos   = '0;
      nxt_o.start = '0;
      nxt_o.kind  = KIND_COMMENT;
      nxt_o.sat   = 1'b0;
      nxt_o.full  = 1'b0;
    end else begin
      nxt_o.mode  = mode_d;
      nxt_o.start = start_d;
      nxt_o.kind  = kind_d;
      nxt_o.sat   = sat_eff;
      if (cur_i.pos < PosCap) begin
        nxt_o.pos  = cur_i.pos + 16'd1;
        nxt_o.full = cur_i.full;
      end else begin
        nxt_o.pos  = cur_i.pos;
        nxt_o.full = 1'b1;
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
// testbench for the gap comment segmenter: self-checking byte stream scanner test
`timescale 1ns / 100ps

module tb;
  import gcs_pkg::*;

  // highest gap position before the counter holds
  localparam int unsigned POS_CAP =
    (GCS_MAX_GAP_BYTES > 65536 ? 65536 : GCS_MAX_GAP_BYTES) - 1;
  // long receiver hold-off and the no-progress limit of the watchdog
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // body bytes of the first long gap, and least length of the second, both sent without idling
  localparam int unsigned LONG_GAP_BYTES = 40;

  // one byte of gap text as it travels on the slave stream
  typedef struct {
    logic [7:0] data;
    logic       last;
  } gap_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;    // last_of_gap
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;           // [15:0] start, [31:16] length, [32] overflow
  logic [1:0]  m_axis_tuser;           // [1:0] segment_kind

  gap_comment_segmenter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // words waiting for the driver, and segments the scanner is expected to report
  gap_word_t   byte_q[$];
  seg_result_t pending_segs[$];
  logic [7:0]  gap_text[$];
  int unsigned queued_words = 0;
  int unsigned errors = 0;

  // idling controls, changed by the stimulus on the falling edge only
  bit          send_gaps = 1'b0;
  bit          recv_stalls = 1'b0;
  int unsigned hold_reqs = 0;

  // ---------------------------------------------------------------------------
  // segment predictor: own copy of the scanner state and of comments_only
  // ---------------------------------------------------------------------------
  bit          only_comments;
  scan_mode_e  mode;
  logic [15:0] gap_pos;
  logic [15:0] seg_start;
  seg_kind_e   pend_kind;
  bit          saturated;
  bit          pos_full;

  function automatic void clear_scan();
    mode      = MODE_IDLE;
    gap_pos   = '0;
    seg_start = '0;
    pend_kind = KIND_COMMENT;
    saturated = 1'b0;
    pos_full  = 1'b0;
  endfunction

  // a finished segment: clip the length, then drop it if comments only are wanted
  function automatic void report_segment(input logic [16:0] len, input seg_kind_e kind);
    seg_result_t seg;
    seg.kind  = kind;
    seg.start = seg_start;
    seg.len   = len[15:0];
    seg.ovf   = saturated;
    if (len > 17'h0FFFF) begin
      seg.len = 16'hFFFF;
      seg.ovf = 1'b1;
    end
    if (!(only_comments && kind != KIND_COMMENT))
      pending_segs.push_back(seg);
  endfunction

  function automatic void scan_byte(input logic [7:0] c, input logic last);
    logic [16:0] here;
    bit          closed;
    closed = 1'b0;
    if (pos_full) saturated = 1'b1;
    here = {1'b0, gap_pos};
    case (mode)
      MODE_SLASH: begin
        if (c == CH_STAR) begin
          mode      = MODE_BLOCK;
          pend_kind = KIND_COMMENT;
        end else if (c == CH_SLASH) begin
          mode      = MODE_LINE;
          pend_kind = KIND_COMMENT;
        end else if (c == CH_LF) begin
          // slash straight before lf: unknown line of one byte
          report_segment(here - {1'b0, seg_start}, KIND_UNKNOWN);
          closed = 1'b1;
          mode   = MODE_IDLE;
        end else begin
          mode      = MODE_LINE;
          pend_kind = KIND_UNKNOWN;
        end
      end
      MODE_LINE: begin
        if (c == CH_LF) begin
          report_segment(here - {1'b0, seg_start}, pend_kind);
          closed = 1'b1;
          mode   = MODE_IDLE;
        end
      end
      MODE_BLOCK: begin
        if (c == CH_STAR) mode = MODE_STAR;
      end
      MODE_STAR: begin
        if (c == CH_SLASH) begin
          report_segment(here + 17'd1 - {1'b0, seg_start}, KIND_COMMENT);
          closed = 1'b1;
          mode   = MODE_IDLE;
        end else if (c != CH_STAR) begin
          mode = MODE_BLOCK;
        end
      end
      default: begin
        mode = MODE_IDLE;
        if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)) begin
          seg_start = gap_pos;
          if (c == CH_SLASH) begin
            mode      = MODE_SLASH;
            pend_kind = KIND_UNKNOWN;
          end else begin
            mode      = MODE_LINE;
            pend_kind = (c == CH_HASH)   ? KIND_COMMENT :
                        (c == CH_DOLLAR) ? KIND_DIRECTIVE : KIND_UNKNOWN;
          end
        end
      end
    endcase
    if (last) begin
      // segment still open at the end of the gap runs to the last byte
      if (!closed && mode != MODE_IDLE)
        report_segment(here + 17'd1 - {1'b0, seg_start},
                       (mode == MODE_SLASH) ? KIND_UNKNOWN : pend_kind);
      clear_scan();
    end else if (gap_pos < POS_CAP) begin
      gap_pos = gap_pos + 16'd1;
    end else begin
      pos_full = 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted byte, checks every accepted segment word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : seg_monitor
    seg_result_t want;
    if (!rst_ni) begin
      only_comments = 1'b0;
      clear_scan();
      pending_segs.delete();
    end else begin
      if (cfg_we_i) only_comments = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) scan_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_segs.size() == 0) begin
          errors++;
          $display("%0t: segment word with nothing expected, got kind %0d start %0d len %0d ovf %0b",
                   $time, m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                   m_axis_tdata[32]);
        end else begin
          want = pending_segs.pop_front();
          check_field("kind", want.kind, m_axis_tuser);
          check_field("start", want.start, m_axis_tdata[15:0]);
          check_field("length", want.len, m_axis_tdata[31:16]);
          check_field("overflow", want.ovf, m_axis_tdata[32]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: bursts of words from byte_q; if send_gaps is set, random gaps in between
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : byte_driver
    gap_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (byte_q.size() != 0) begin
        w = byte_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w.data;
        s_axis_tlast  <= w.last;
        // end of a burst: pick the next one and the pause before it
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= send_gaps ? $urandom_range(1, 8) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: alternating ready and stall runs, plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned run_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen     <= hold_reqs;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;
    end else if (!recv_stalls) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= !m_axis_tready;
      run_left      <= m_axis_tready ? $urandom_range(0, 4) : $urandom_range(0, 10);
    end
  end

  // watchdog: too long without any word moving on either side
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] any_char();
    logic [7:0] specials [8];
    specials = '{CH_SLASH, CH_STAR, CH_HASH, CH_DOLLAR, CH_LF, CH_CR, CH_TAB, CH_SPACE};
    if ($urandom_range(0, 1) == 0) return specials[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] line_char();
    logic [7:0] c;
    c = any_char();
    while (c == CH_LF) c = any_char();
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    logic [7:0] blanks [4];
    blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
    return blanks[$urandom_range(0, 3)];
  endfunction

  task automatic push_word(input logic [7:0] data, input logic last);
    gap_word_t w;
    w.data = data;
    w.last = last;
    byte_q.push_back(w);
    queued_words++;
  endtask

  // hand the text built in gap_text to the driver, tlast on its final byte
  task automatic queue_gap();
    foreach (gap_text[i]) push_word(gap_text[i], i == gap_text.size() - 1);
    gap_text.delete();
  endtask

  // one well-formed segment; the final one of a gap may stay open
  task automatic add_segment(input bit final_seg);
    int unsigned body;
    body = $urandom_range(0, 8);
    case ($urandom_range(0, 5))
      0: gap_text.push_back(CH_HASH);
      1: begin
        gap_text.push_back(CH_SLASH);
        gap_text.push_back(CH_SLASH);
      end
      2: gap_text.push_back(CH_DOLLAR);
      3: gap_text.push_back(line_char());
      4: begin
        gap_text.push_back(CH_SLASH);
        gap_text.push_back(CH_STAR);
        repeat (body) gap_text.push_back(any_char());
        if (!final_seg || $urandom_range(0, 1) == 0) begin
          gap_text.push_back(CH_STAR);
          gap_text.push_back(CH_SLASH);
        end
        return;
      end
      default: gap_text.push_back(CH_SLASH);
    endcase
    repeat (body) gap_text.push_back(line_char());
    if (!final_seg || $urandom_range(0, 2) != 0) gap_text.push_back(CH_LF);
  endtask

  task automatic make_gap(input int unsigned min_len, input int unsigned n_seg);
    int unsigned k;
    k = 0;
    while (k < n_seg || gap_text.size() < min_len) begin
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) gap_text.push_back(blank_char());
      k++;
      add_segment(k >= n_seg && gap_text.size() >= min_len);
    end
    queue_gap();
  endtask

  // mostly well-formed gaps, with some raw noise and cut-off segments mixed in
  task automatic run_random(input int unsigned n_words);
    int unsigned target;
    target = queued_words + n_words;
    while (queued_words < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 16)) gap_text.push_back(any_char());
        queue_gap();
      end else begin
        make_gap(1, $urandom_range(1, 4));
      end
    end
  endtask

  // wait until every word has gone in and every segment has come out
  task automatic drain_all();
    while (byte_q.size() != 0 || s_axis_tvalid || pending_segs.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_comments_only(input logic value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // short gaps: blanks, every kind, slash cases, block closing and open ends
  task automatic run_directed();
    // blanks then a hash comment holding the all-ones byte
    push_word(CH_SPACE, 1'b0);
    push_word(CH_TAB, 1'b0);
    push_word(CH_CR, 1'b0);
    push_word(CH_LF, 1'b0);
    push_word(CH_HASH, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(CH_LF, 1'b0);
    push_word(8'h00, 1'b1);
    // directive ended by an lf on the last byte
    push_word(CH_DOLLAR, 1'b0);
    push_word(CH_LF, 1'b1);
    // lone slash before lf, then a slash-slash comment left open
    push_word(CH_SLASH, 1'b0);
    push_word(CH_LF, 1'b0);
    push_word(CH_SLASH, 1'b0);
    push_word(CH_SLASH, 1'b0);
    push_word(8'h78, 1'b1);
    // slash-star-slash does not close, the star-slash after it does
    push_word(CH_SLASH, 1'b0);
    push_word(CH_STAR, 1'b0);
    push_word(CH_SLASH, 1'b0);
    push_word(CH_STAR, 1'b0);
    push_word(CH_STAR, 1'b0);
    push_word(CH_SLASH, 1'b1);
    // slash as the only byte of a gap
    push_word(CH_SLASH, 1'b1);
    // block comment cut off by the end of the gap
    push_word(CH_SLASH, 1'b0);
    push_word(CH_STAR, 1'b0);
    push_word(8'h61, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_comments_only(1'b0);
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    run_directed();
    drain_all();

    // longer gaps, no idling: a block comment that may be left open, then one gap of many lines
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    gap_text.push_back(CH_SLASH);
    gap_text.push_back(CH_STAR);
    repeat (LONG_GAP_BYTES) gap_text.push_back(line_char() == CH_STAR ? 8'h41 : any_char());
    queue_gap();
    make_gap(LONG_GAP_BYTES, 0);
    drain_all();

    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    run_random(110);
    drain_all();

    write_comments_only(1'b1);
    run_directed();
    run_random(110);
    drain_all();

    // receiver holds off while the sender keeps offering, so the input stalls
    send_gaps = 1'b0;
    hold_reqs++;
    run_random(60);
    drain_all();

    write_comments_only(1'b0);
    recv_stalls = 1'b0;
    run_random(50);
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    run_random(50);
    drain_all();

    repeat (20) @(posedge clk_i);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
